>>> sv/mp3seq_pkg.sv
// shared types, codes and frame helpers for the mp3 serial sequencer
`timescale 1ns / 1ps

package mp3seq_pkg;

   // input item kinds, carried on req_tuser
   typedef enum logic [1:0] {
      KIND_RX    = 2'd0,
      KIND_PLAY  = 2'd1,
      KIND_START = 2'd2
   } kind_type;

   // controller modes, reported as ctrl_state
   typedef enum logic [1:0] {
      MODE_INIT  = 2'd0,
      MODE_WAIT  = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_PLAY  = 2'd3
   } mode_type;

   // which command frame the front end asks for
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_SELECT,
      EMIT_QUERY,
      EMIT_PLAY
   } emit_type;

   // frame framing bytes
   localparam logic [7:0] FRAME_START = 8'h7E;
   localparam logic [7:0] FRAME_VER   = 8'hFF;
   localparam logic [7:0] FRAME_LEN   = 8'h06;
   localparam logic [7:0] FRAME_END   = 8'hEF;

   // outgoing command codes
   localparam logic [7:0] CMD_SELECT = 8'h09;
   localparam logic [7:0] CMD_QUERY  = 8'h4E;
   localparam logic [7:0] CMD_PLAY   = 8'h0F;

   // reply codes from the module
   localparam logic [7:0] RPL_MEDIA  = 8'h3A;
   localparam logic [7:0] RPL_COUNT  = 8'h4E;
   localparam logic [7:0] RPL_ERROR  = 8'h40;
   localparam logic [7:0] RPL_FINISH = 8'h3D;

   // byte positions inside a received frame
   localparam int CODE_POS  = 3;
   localparam int VALHI_POS = 5;
   localparam int VALLO_POS = 6;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int FRAME_BYTES = 8;
   localparam int BIDX_W      = $clog2(FRAME_BYTES);

   typedef struct packed {
      logic [7:0] cmd;
      logic [7:0] d1;
      logic [7:0] d2;
      mode_type   state;
      logic [7:0] track;
   } frame_cmd_type;

   // byte idx of the eight-byte frame 7E FF 06 cmd 00 d1 d2 EF
   function automatic logic [7:0] frame_byte(frame_cmd_type f, logic [BIDX_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = FRAME_START;
         3'd1:    b = FRAME_VER;
         3'd2:    b = FRAME_LEN;
         3'd3:    b = f.cmd;
         3'd4:    b = 8'h00;
         3'd5:    b = f.d1;
         3'd6:    b = f.d2;
         default: b = FRAME_END;
      endcase
      return b;
   endfunction

endpackage

>>> sv/mp3seq_front.sv
// front end: deframes received bytes, runs the controller and requests frames
`timescale 1ns / 1ps

module mp3seq_front
   import mp3seq_pkg::*;
#(
   parameter int FRAME_LIMIT = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   output logic          item_ready,
   input  logic [1:0]    kind,
   input  logic [7:0]    rx_byte,
   input  logic [7:0]    album,
   input  logic [1:0]    finish_repeats,
   input  logic [7:0]    device_code,
   input  logic          q_full,
   output logic          push,
   output frame_cmd_type push_data
);

   localparam int POS_W = $clog2(FRAME_LIMIT);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LIMIT - 1);

   mode_type         mode_ff, mode_in;
   logic [7:0]       album_ff, album_in;
   logic [7:0]       track_ff, track_in;
   logic [1:0]       finish_ff, finish_in;
   logic             open_ff, open_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       code_ff, code_in;
   logic [15:0]      value_ff, value_in;

   emit_type         emit;
   logic             accept;
   logic [1:0]       fs_next;

   assign item_ready = !q_full;
   assign accept     = item_valid && item_ready;
   assign fs_next    = finish_ff + 2'd1;

   // next state
   always_comb begin
      mode_in   = mode_ff;
      album_in  = album_ff;
      track_in  = track_ff;
      finish_in = finish_ff;
      open_in   = open_ff;
      pos_in    = pos_ff;
      code_in   = code_ff;
      value_in  = value_ff;
      emit      = EMIT_NONE;
      if (accept) begin
         case (kind)
            KIND_RX: begin
               if (!open_ff) begin
                  if (rx_byte == FRAME_START) begin
                     open_in = 1'b1;
                     pos_in  = POS_W'(1);
                  end
               end else begin
                  if (pos_ff == POS_W'(CODE_POS)) begin
                     code_in = rx_byte;
                  end else if (pos_ff == POS_W'(VALHI_POS)) begin
                     value_in = {rx_byte, value_ff[7:0]};
                  end else if (pos_ff == POS_W'(VALLO_POS)) begin
                     value_in = {value_ff[15:8], rx_byte};
                  end
                  if (rx_byte == FRAME_END) begin
                     open_in = 1'b0;
                     case (mode_ff)
                        MODE_INIT: begin
                           if (code_in == RPL_MEDIA && value_in == {8'h00, device_code}) begin
                              mode_in = MODE_WAIT;
                           end
                        end
                        MODE_QUERY: begin
                           if (code_in == RPL_COUNT) begin
                              track_in  = 8'd1;
                              mode_in   = MODE_PLAY;
                              finish_in = 2'd0;
                              emit      = EMIT_PLAY;
                           end else if (code_in == RPL_ERROR) begin
                              mode_in = MODE_WAIT;
                           end
                        end
                        MODE_PLAY: begin
                           if (code_in == RPL_FINISH) begin
                              if (fs_next == finish_repeats) begin
                                 track_in  = track_ff + 8'd1;
                                 finish_in = 2'd0;
                                 emit      = EMIT_PLAY;
                              end else begin
                                 finish_in = fs_next;
                              end
                           end else if (code_in == RPL_ERROR) begin
                              mode_in = MODE_WAIT;
                           end
                        end
                        default: ;  // replies in wait are dropped
                     endcase
                  end else if (pos_ff < POS_LAST) begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
            end
            KIND_PLAY: begin
               album_in = album;
               if (mode_ff == MODE_WAIT) begin
                  mode_in = MODE_QUERY;
                  emit    = EMIT_QUERY;
               end
            end
            KIND_START: begin
               mode_in = MODE_INIT;
               open_in = 1'b0;
               pos_in  = '0;
               emit    = EMIT_SELECT;
            end
            default: ;  // unused kind
         endcase
      end
   end

   // outputs: frame request into the queue
   always_comb begin
      push            = (emit != EMIT_NONE);
      push_data.state = mode_in;
      push_data.track = track_in;
      case (emit)
         EMIT_SELECT: begin
            push_data.cmd = CMD_SELECT;
            push_data.d1  = 8'h00;
            push_data.d2  = device_code;
         end
         EMIT_QUERY: begin
            push_data.cmd = CMD_QUERY;
            push_data.d1  = 8'h00;
            push_data.d2  = album;
         end
         EMIT_PLAY: begin
            push_data.cmd = CMD_PLAY;
            push_data.d1  = album_ff;
            push_data.d2  = track_in;
         end
         default: begin
            push_data.cmd = 8'h00;
            push_data.d1  = 8'h00;
            push_data.d2  = 8'h00;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_INIT;
         album_ff  <= 8'd0;
         track_ff  <= 8'd0;
         finish_ff <= 2'd0;
         open_ff   <= 1'b0;
         pos_ff    <= '0;
         code_ff   <= 8'd0;
         value_ff  <= 16'd0;
      end else begin
         mode_ff   <= mode_in;
         album_ff  <= album_in;
         track_ff  <= track_in;
         finish_ff <= finish_in;
         open_ff   <= open_in;
         pos_ff    <= pos_in;
         code_ff   <= code_in;
         value_ff  <= value_in;
      end
   end

endmodule

>>> sv/mp3seq_queue.sv
// short command queue between the front end and the frame serializer
`timescale 1ns / 1ps

module mp3seq_queue
   import mp3seq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frame_cmd_type push_data,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output frame_cmd_type head
);

   frame_cmd_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> sv/mp3seq_back.sv
// back end: serializes one queued command into eight frame bytes
`timescale 1ns / 1ps

module mp3seq_back
   import mp3seq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  frame_cmd_type q_head,
   output logic          pop,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [7:0]    out_byte,
   output logic          out_last,
   output mode_type      out_state,
   output logic [7:0]    out_track
);

   frame_cmd_type     cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic [BIDX_W-1:0] idx_ff, idx_in;
   logic              last_done;

   assign out_valid = busy_ff;
   assign out_last  = (idx_ff == BIDX_W'(FRAME_BYTES - 1));
   assign out_byte  = frame_byte(cur_ff, idx_ff);
   assign out_state = cur_ff.state;
   assign out_track = cur_ff.track;

   assign last_done = busy_ff && out_ready && out_last;
   assign pop       = !q_empty && (!busy_ff || last_done);

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         cur_in  = q_head;
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (last_done) begin
         busy_in = 1'b0;
      end else if (busy_ff && out_ready) begin
         idx_in = idx_ff + BIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

>>> sv/mp3_module_serial_sequencer_core.sv
// top level of the serial mp3 module sequencer
`timescale 1ns / 1ps

// Controller for a serial mp3 playback module.
// req channel: one transaction per item; req_tuser is the kind (received byte,
//   play album request, start controller), req_tdata carries rx_byte and album.
// rsp channel: one transaction per byte of an outgoing 8-byte command frame,
//   rsp_tlast on the eighth byte; rsp_tdata also carries the controller state
//   and track number as they stood after the item that caused the frame.
// csr port: csr_we writes csr_wdata into register csr_index at the clock edge
//   (0 finish_repeats, 1 device_code); write only while the block is idle.
// Frame path: an item that causes a frame is written into the command queue, and
//   the serializer loads it from there into its register if it is free; only then
//   is the first byte of the frame valid on rsp.
// Throughput: the front end takes one item per cycle while the two-entry
//   command queue has room; each frame holds the rsp side for its eight bytes,
//   so items that cause frames are paced by the serializer.
// Reset: synchronous; controller goes to init, deframer closed, queue empty,
//   finish_repeats and device_code return to 2.
// When the receiver stalls, the serializer holds its byte, the queue fills,
//   and req_tready drops once both queue entries are taken.

module mp3_module_serial_sequencer_core
   import mp3seq_pkg::*;
#(
   parameter int FRAME_LIMIT = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte [7:0], album [15:8]
   input  logic [1:0]  req_tuser,   // kind [1:0]
   // frame bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tx_byte [7:0], ctrl_state [9:8], track [17:10], zero
   output logic        rsp_tlast,   // tx_last
   // configuration writes
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam logic CSR_FINISH = 1'b0;
   localparam logic CSR_DEVICE = 1'b1;

   // configuration registers
   logic [1:0] finish_repeats_ff, finish_repeats_in;
   logic [7:0] device_code_ff, device_code_in;

   // front to queue, queue to back
   logic          push;
   frame_cmd_type push_data;
   logic          q_full;
   logic          q_empty;
   frame_cmd_type q_head;
   logic          pop;

   logic [7:0] tx_byte;
   mode_type   tx_state;
   logic [7:0] tx_track;

   always_comb begin
      finish_repeats_in = finish_repeats_ff;
      device_code_in    = device_code_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FINISH: finish_repeats_in = csr_wdata[1:0];
            CSR_DEVICE: device_code_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finish_repeats_ff <= 2'd2;
         device_code_ff    <= 8'd2;
      end else begin
         finish_repeats_ff <= finish_repeats_in;
         device_code_ff    <= device_code_in;
      end
   end

   // deframer and controller
   mp3seq_front #(
      .FRAME_LIMIT(FRAME_LIMIT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (req_tvalid),
      .item_ready    (req_tready),
      .kind          (req_tuser),
      .rx_byte       (req_tdata[7:0]),
      .album         (req_tdata[15:8]),
      .finish_repeats(finish_repeats_ff),
      .device_code   (device_code_ff),
      .q_full        (q_full),
      .push          (push),
      .push_data     (push_data)
   );

   // pending frame commands
   mp3seq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   // frame serializer
   mp3seq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .pop      (pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_byte (tx_byte),
      .out_last (rsp_tlast),
      .out_state(tx_state),
      .out_track(tx_track)
   );

   assign rsp_tdata = {6'd0, tx_track, tx_state, tx_byte};

   // a frame request never lands on a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("frame request pushed into full queue");

   // a start item always leaves a frame waiting in the queue
   a_start_queued: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == KIND_START) |=> !q_empty)
      else $error("start item left no select frame queued");

   // the final byte of each frame is the end marker
   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tdata[7:0] == FRAME_END)
      else $error("last frame byte is not the end marker");

   // nothing is popped from an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("serializer popped empty queue");

endmodule

>>> tb/mp3_module_serial_sequencer_core_tb.sv
// self-checking testbench for the serial mp3 module sequencer core
`timescale 1ns / 1ps

module mp3_module_serial_sequencer_core_tb;
   import mp3seq_pkg::*;

   localparam int FRAME_LIMIT   = 16;
   localparam int SETTLE_CYCLES = 8;      // margin over the frame latency
   localparam int HOLD_CYCLES   = 80;     // long receiver stall, fills the command queue
   localparam longint WATCHDOG_NS = 2_000_000;

   // kind code the block does not use
   localparam logic [1:0] KIND_NONE = 2'd3;

   // register indexes on the csr port
   localparam logic REG_REPEATS = 1'b0;
   localparam logic REG_DEVICE  = 1'b1;

   // one byte of an outgoing command frame as it should appear on rsp
   typedef struct {
      logic [7:0] tx_byte;
      logic       tx_last;
      logic [1:0] ctrl_state;
      logic [7:0] track;
   } frame_beat_type;

   // directed stimulus row; the frame fields hold only where typed and framed are set
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
      logic [7:0] album;
      logic       typed;
      logic       framed;
      logic [7:0] cmd;
      logic [7:0] d1;
      logic [7:0] d2;
      logic [1:0] state;
      logic [7:0] track;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 24;

   // register values at reset: 2 track-finished replies per track, device 2
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // unused kind with all-ones data: nothing happens
      '{KIND_NONE, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      // play request while in init: album stored, nothing sent
      '{KIND_PLAY, 8'h00, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      // start: select-device frame for device 2
      '{KIND_START, 8'h00, 8'h00, 1'b1, 1'b1, CMD_SELECT, 8'h00, 8'h02, MODE_INIT, 8'h00},
      // media-inserted reply naming device 2, goes to wait
      '{KIND_RX, FRAME_START, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, 8'h06, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, RPL_MEDIA, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, 8'h02, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, FRAME_END, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      // play request for album 0 in wait: track-count query
      '{KIND_PLAY, 8'hFF, 8'h00, 1'b1, 1'b1, CMD_QUERY, 8'h00, 8'h00, MODE_QUERY, 8'h00},
      // short count reply, value bytes never arrive: play frame for track 1
      '{KIND_RX, FRAME_START, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, FRAME_START, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, FRAME_START, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, RPL_COUNT, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, FRAME_END, 8'h00, 1'b1, 1'b1, CMD_PLAY, 8'h00, 8'h01, MODE_PLAY, 8'h01},
      // short error reply: back to wait
      '{KIND_RX, FRAME_START, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, RPL_ERROR, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      '{KIND_RX, FRAME_END, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00},
      // start while running: select frame again, track kept
      '{KIND_START, 8'h00, 8'hFF, 1'b1, 1'b1, CMD_SELECT, 8'h00, 8'h02, MODE_INIT, 8'h01},
      '{KIND_NONE, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, MODE_INIT, 8'h00}
   };

   localparam logic [7:0] REPLY_CODES [4] = '{RPL_MEDIA, RPL_COUNT, RPL_ERROR, RPL_FINISH};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   mp3_module_serial_sequencer_core #(
      .FRAME_LIMIT(FRAME_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // frame bytes still owed by the block, oldest first
   frame_beat_type tx_due_q [$];
   frame_beat_type seen_beat;

   int mismatch_count = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   logic hold_rsp     = 1'b0;

   // sequencer shadow state, mirrors the block after every accepted transaction
   mode_type    seq_mode          = MODE_INIT;
   logic        album_req_pending = 1'b0;
   logic [7:0]  album_sel         = 8'h00;
   logic [15:0] track_count       = 16'h0000;
   logic [7:0]  track_now         = 8'h00;
   logic [1:0]  finish_count      = 2'd0;
   logic        rx_in_frame       = 1'b0;
   int          rx_pos            = 0;
   logic [7:0]  last_code         = 8'h00;
   logic [15:0] last_value        = 16'h0000;
   logic [1:0]  rep_cfg           = 2'd2;
   logic [7:0]  dev_cfg           = 8'h02;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // advance the shadow sequencer by one item; returns 1 when a frame goes out
   function automatic bit sequencer_step(input logic [1:0] kind, input logic [7:0] rxb,
                                         input logic [7:0] alb, output logic [7:0] cmd,
                                         output logic [7:0] d1, output logic [7:0] d2);
      cmd = 8'h00;
      d1  = 8'h00;
      d2  = 8'h00;
      case (kind)
         KIND_RX: begin
            // outside a frame only the start byte matters
            if (!rx_in_frame) begin
               if (rxb == FRAME_START) begin
                  rx_in_frame = 1'b1;
                  rx_pos      = 1;
               end
               return 1'b0;
            end
            if (rx_pos == CODE_POS)
               last_code = rxb;
            else if (rx_pos == VALHI_POS)
               last_value[15:8] = rxb;
            else if (rx_pos == VALLO_POS)
               last_value[7:0] = rxb;
            if (rxb == FRAME_END) begin
               rx_in_frame = 1'b0;
               case (seq_mode)
                  MODE_INIT: begin
                     if (last_code == RPL_MEDIA && last_value == {8'h00, dev_cfg}) begin
                        seq_mode          = MODE_WAIT;
                        album_req_pending = 1'b0;
                     end
                  end
                  MODE_QUERY: begin
                     if (last_code == RPL_COUNT) begin
                        track_count  = last_value;
                        track_now    = 8'h01;
                        seq_mode     = MODE_PLAY;
                        finish_count = 2'd0;
                        cmd = CMD_PLAY;
                        d1  = album_sel;
                        d2  = track_now;
                        return 1'b1;
                     end
                     if (last_code == RPL_ERROR) begin
                        seq_mode          = MODE_WAIT;
                        album_req_pending = 1'b0;
                     end
                  end
                  MODE_PLAY: begin
                     if (last_code == RPL_FINISH) begin
                        // two-bit counter, so a zero setting means every fourth reply
                        finish_count = finish_count + 2'd1;
                        if (finish_count == rep_cfg) begin
                           track_now    = track_now + 8'd1;
                           seq_mode     = MODE_PLAY;
                           finish_count = 2'd0;
                           cmd = CMD_PLAY;
                           d1  = album_sel;
                           d2  = track_now;
                           return 1'b1;
                        end
                     end
                     if (last_code == RPL_ERROR) begin
                        seq_mode          = MODE_WAIT;
                        album_req_pending = 1'b0;
                     end
                  end
                  default: ;   // frames in wait are dropped
               endcase
               return 1'b0;
            end
            // long frames park on the last position
            if (rx_pos < FRAME_LIMIT - 1)
               rx_pos++;
            return 1'b0;
         end
         KIND_PLAY: begin
            album_sel         = alb;
            album_req_pending = 1'b1;
            if (seq_mode == MODE_WAIT) begin
               seq_mode = MODE_QUERY;
               cmd = CMD_QUERY;
               d2  = album_sel;
               return 1'b1;
            end
            return 1'b0;
         end
         KIND_START: begin
            seq_mode    = MODE_INIT;
            rx_in_frame = 1'b0;
            rx_pos      = 0;
            cmd = CMD_SELECT;
            d2  = dev_cfg;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // queue the eight bytes of one command frame
   function automatic void push_frame(input logic [7:0] cmd, input logic [7:0] d1,
                                      input logic [7:0] d2, input logic [1:0] state,
                                      input logic [7:0] track);
      logic [7:0] bytes [8];
      frame_beat_type beat;
      bytes = '{FRAME_START, FRAME_VER, FRAME_LEN, cmd, 8'h00, d1, d2, FRAME_END};
      for (int k = 0; k < 8; k++) begin
         beat.tx_byte    = bytes[k];
         beat.tx_last    = (k == 7);
         beat.ctrl_state = state;
         beat.track      = track;
         tx_due_q.push_back(beat);
      end
   endfunction

   // random frame filler that cannot close the frame
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == FRAME_END);
      return b;
   endfunction

   // offer one item, wait for its transaction, then predict; valid stays high on return
   task automatic send_item(input logic [1:0] kind, input logic [7:0] rxb,
                            input logic [7:0] alb, input bit predicted);
      logic [7:0] cmd;
      logic [7:0] d1;
      logic [7:0] d2;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {alb, rxb};
      do @(posedge clock); while (!req_tready);
      if (sequencer_step(kind, rxb, alb, cmd, d1, d2) && predicted)
         push_frame(cmd, d1, d2, seq_mode, track_now);
      if (kind != KIND_NONE)
         items_sent++;
   endtask

   // send a reply frame byte by byte; short frames stop after the code
   task automatic send_reply(input logic [7:0] code, input logic [15:0] value,
                             input bit cut_short, input int extra);
      logic [7:0] body [$];
      body.push_back(FRAME_START);
      body.push_back(body_byte());
      body.push_back(body_byte());
      body.push_back(code);
      if (!cut_short) begin
         body.push_back(body_byte());
         body.push_back(value[15:8]);
         body.push_back(value[7:0]);
         repeat (extra) body.push_back(body_byte());
      end
      body.push_back(FRAME_END);
      foreach (body[i])
         send_item(KIND_RX, body[i], 8'($urandom_range(255)), 1'b1);
   endtask

   // one register write per clock; the caller lowers csr_we after the last
   task automatic write_reg(input logic index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == REG_REPEATS)
         rep_cfg = value[1:0];
      else
         dev_cfg = value;
      @(posedge clock);
   endtask

   // stop offering, let every frame drain, then reprogram both registers
   task automatic set_config(input logic [1:0] repeats, input logic [7:0] device);
      req_tvalid <= 1'b0;
      while (tx_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      // upper bits of the repeat register write are don't-care
      write_reg(REG_REPEATS, {6'($urandom_range(63)), repeats});
      write_reg(REG_DEVICE, device);
      csr_we <= 1'b0;
   endtask

   // mostly replies that move the controller on, the rest noise and stray items
   task automatic run_random(input int count);
      int pick;
      int goal;
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            case (seq_mode)
               MODE_INIT: begin
                  if ($urandom_range(4) != 0)
                     send_reply(RPL_MEDIA, {8'h00, dev_cfg}, 1'b0, 0);
                  else
                     send_reply(RPL_MEDIA, 16'($urandom_range(65535)), 1'b0, 0);
               end
               MODE_WAIT: begin
                  if ($urandom_range(5) != 0)
                     send_item(KIND_PLAY, 8'($urandom_range(255)), 8'($urandom_range(255)),
                               1'b1);
                  else
                     send_reply(RPL_FINISH, 16'($urandom_range(65535)), 1'b0, 0);
               end
               MODE_QUERY: begin
                  if ($urandom_range(4) != 0)
                     send_reply(RPL_COUNT, 16'($urandom_range(65535)),
                                $urandom_range(3) == 0, 0);
                  else
                     send_reply(RPL_ERROR, 16'($urandom_range(65535)), 1'b0, 0);
               end
               default: begin
                  if ($urandom_range(6) != 0)
                     send_reply(RPL_FINISH, 16'($urandom_range(65535)),
                                $urandom_range(2) == 0, 0);
                  else
                     send_reply(RPL_ERROR, 16'($urandom_range(65535)),
                                $urandom_range(1) == 0, 0);
               end
            endcase
         end else if (pick < 78) begin
            send_item(KIND_START, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
         end else if (pick < 85) begin
            send_item(KIND_PLAY, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
         end else if (pick < 91) begin
            send_item(KIND_RX, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
         end else if (pick < 96) begin
            // long frame runs past the position limit
            send_reply(REPLY_CODES[$urandom_range(3)], 16'($urandom_range(65535)), 1'b0,
                       $urandom_range(8, 14));
         end else begin
            send_item(KIND_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
         end
      end
   endtask

   // receiver: random backpressure, or one long hold when the sender asks for it
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // every rsp transaction is checked against the oldest owed frame byte
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tx_due_q.size() == 0) begin
            $error("unexpected frame byte %h with no transaction owed", rsp_tdata[7:0]);
            mismatch_count++;
         end else begin
            seen_beat = tx_due_q.pop_front();
            if (rsp_tdata[7:0] !== seen_beat.tx_byte) begin
               $error("tx_byte expected %h, actual %h", seen_beat.tx_byte, rsp_tdata[7:0]);
               mismatch_count++;
            end
            if (rsp_tlast !== seen_beat.tx_last) begin
               $error("tx_last expected %b, actual %b", seen_beat.tx_last, rsp_tlast);
               mismatch_count++;
            end
            if (rsp_tdata[9:8] !== seen_beat.ctrl_state) begin
               $error("ctrl_state expected %0d, actual %0d", seen_beat.ctrl_state,
                      rsp_tdata[9:8]);
               mismatch_count++;
            end
            if (rsp_tdata[17:10] !== seen_beat.track) begin
               $error("track expected %h, actual %h", seen_beat.track, rsp_tdata[17:10]);
               mismatch_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      stim_row_type row;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_RX;
      csr_we     = 1'b0;
      csr_index  = REG_REPEATS;
      csr_wdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed walk at reset register values, sender and receiver both idling
      send_idle_pct = 34;
      recv_idle_pct = 48;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         send_item(row.kind, row.rx_byte, row.album, !row.typed);
         if (row.typed && row.framed)
            push_frame(row.cmd, row.d1, row.d2, row.state, row.track);
      end

      // one reply per track, all-ones device
      set_config(2'd1, 8'hFF);
      run_random(20);

      // idling swapped, three replies per track, device zero
      send_idle_pct = 48;
      recv_idle_pct = 34;
      set_config(2'd3, 8'h00);
      run_random(20);

      // no idling, zero repeat setting wraps the finish counter
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(2'd0, 8'($urandom_range(255)));
      run_random(10);
      // receiver stalls while starts keep coming, so req_tready must drop
      hold_rsp = 1'b1;
      repeat (6)
         send_item(KIND_START, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
      run_random(10);

      // step the track number with one reply per track
      set_config(2'd1, 8'($urandom_range(255)));
      send_item(KIND_START, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
      send_reply(RPL_MEDIA, {8'h00, dev_cfg}, 1'b0, 0);
      send_item(KIND_PLAY, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
      send_reply(RPL_COUNT, 16'($urandom_range(65535)), 1'b0, 0);
      send_reply(RPL_FINISH, 16'($urandom_range(65535)), 1'b0, 0);
      // bare frames reuse the stored finish code
      repeat (6) begin
         send_item(KIND_RX, FRAME_START, 8'($urandom_range(255)), 1'b1);
         send_item(KIND_RX, FRAME_END, 8'($urandom_range(255)), 1'b1);
      end

      req_tvalid <= 1'b0;
      while (tx_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("mp3_module_serial_sequencer_core_tb OK");
      else
         $display("mp3_module_serial_sequencer_core_tb NOT OK");
      $finish;
   end

   // watchdog for a hung handshake
   initial begin
      #(WATCHDOG_NS);
      $display("mp3_module_serial_sequencer_core_tb NOT OK");
      $finish;
   end

endmodule

>>> sim.f
sv/mp3seq_pkg.sv
sv/mp3seq_front.sv
sv/mp3seq_queue.sv
sv/mp3seq_back.sv
sv/mp3_module_serial_sequencer_core.sv
tb/mp3_module_serial_sequencer_core_tb.sv
